// ----- hw/rtl/first_fit_heap_allocator_top_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the first-fit heap allocator.
// Each macro expands to one labeled concurrent assertion that is clocked on
// clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_HEAP_ALLOCATOR_TOP_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_TOP_ASSERT_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define FFHA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define FFHA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/ffha_pkg.sv -----
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types and constants of the first-fit heap allocator: operation
// codes, request and response payloads, and header word constants.
// ----------------------------------------------------------------------------
package ffha_pkg;

  // Default number of 13-bit header words in the store.
  localparam int unsigned HEAP_WORDS_DEF = 1024;

  // Header word width and field widths.
  localparam int unsigned HDR_W  = 13;
  localparam int unsigned CFG_W  = 12;
  localparam int unsigned BYTE_W = 12;

  // Header value that marks the end of the block list.
  localparam logic [HDR_W-1:0] END_MARK = 13'd1;

  // Heap size used to format the store after reset.
  localparam logic [CFG_W-1:0] HEAP_SIZE_RST = 12'd4084;

  // Operation codes.
  typedef enum logic [1:0] {
    FUNC_ALLOC = 2'd0,
    FUNC_FREE  = 2'd1,
    FUNC_MERGE = 2'd2,
    FUNC_NOP   = 2'd3
  } func_e;

  // One request item.
  typedef struct packed {
    func_e             func;
    logic [BYTE_W-1:0] request_bytes;
    logic [BYTE_W-1:0] address;
  } ffha_req_t;

  // One response item.
  typedef struct packed {
    logic              ok;
    logic [BYTE_W-1:0] payload_offset;
    logic [HDR_W-1:0]  granted_bytes;
  } ffha_rsp_t;

endpackage

// ----- hw/rtl/first_fit_heap_allocator_top.sv -----
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_top
// First-fit heap allocator over an implicit list of block headers held in
// a word store, with allocate, free and coalesce operations.
//
//   Channel   Handshake                 Payload
//   request   start high, busy low      req_i (func, request_bytes, address)
//   response  done_o strobe, one cycle  rsp_o (ok, payload_offset, granted_bytes)
//   config    cfg_valid_i / cfg_ready_o cfg_data_i (heap_size)
//
// Allocate reads and fit-checks one header per block, steps past each block
// skipped, then writes the remainder header and marks the granted block;
// coalesce reads header after header; free reads and rewrites one header.
// The steps follow from the single read port of the header store and the
// one shared adder, used once per cycle by the sequencer.
// After reset and after every heap_size write a clearing pass over all
// HEAP_WORDS words formats the store; busy stays high during it.
// The response strobe cannot be held off; results appear once, in order.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_top #(
  parameter int unsigned HEAP_WORDS = ffha_pkg::HEAP_WORDS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  ffha_pkg::ffha_req_t        req_i,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [ffha_pkg::CFG_W-1:0] cfg_data_i,
  output logic                       done_o,
  output ffha_pkg::ffha_rsp_t        rsp_o
);

  import ffha_pkg::*;

  localparam int unsigned IDX_W = $clog2(HEAP_WORDS);
  localparam int unsigned UW    = ((IDX_W > 12) ? IDX_W : 12) + 1;

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [HDR_W-1:0] mem_wdata;
  logic [IDX_W-1:0] mem_raddr;
  logic [HDR_W-1:0] mem_rdata;
  logic [UW-1:0]    alu_a;
  logic [UW-1:0]    alu_b;
  logic             alu_sub;
  logic [UW-1:0]    alu_res;
  logic             alu_cout;

  // Sequencer.
  ffha_seq #(
    .HEAP_WORDS (HEAP_WORDS),
    .IDX_W      (IDX_W),
    .UW         (UW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_o      (busy),
    .req_i       (req_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .done_o      (done_o),
    .rsp_o       (rsp_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .alu_a_o     (alu_a),
    .alu_b_o     (alu_b),
    .alu_sub_o   (alu_sub),
    .alu_res_i   (alu_res),
    .alu_cout_i  (alu_cout)
  );

  // Header store.
  ffha_ram #(
    .W     (HDR_W),
    .DEPTH (HEAP_WORDS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Shared add/subtract unit.
  ffha_unit #(
    .W (UW)
  ) u_unit (
    .a_i    (alu_a),
    .b_i    (alu_b),
    .sub_i  (alu_sub),
    .res_o  (alu_res),
    .cout_o (alu_cout)
  );

endmodule

// ----- hw/rtl/ffha_ram.sv -----
// ----------------------------------------------------------------------------
// ffha_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read data output.
// ----------------------------------------------------------------------------
module ffha_ram #(
  parameter int unsigned W     = 13,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [W-1:0]             wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [W-1:0]             rdata_o
);

  logic [W-1:0] mem_q [DEPTH];
  logic [W-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/ffha_unit.sv -----
// ----------------------------------------------------------------------------
// ffha_unit
// Shared add/subtract unit of the allocator. It serves index stepping,
// split addresses, fit checks (subtract with borrow) and block merging.
// ----------------------------------------------------------------------------
module ffha_unit #(
  parameter int unsigned W = 13
) (
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  input  logic         sub_i,
  output logic [W-1:0] res_o,
  output logic         cout_o
);

  logic [W:0] full;

  // One adder; on subtract the carry bit flags a borrow (a below b).
  always_comb begin
    if (sub_i) begin
      full = {1'b0, a_i} - {1'b0, b_i};
    end else begin
      full = {1'b0, a_i} + {1'b0, b_i};
    end
  end

  assign res_o  = full[W-1:0];
  assign cout_o = full[W];

endmodule

// ----- hw/rtl/ffha_seq.sv -----
// ----------------------------------------------------------------------------
// ffha_seq
// Sequencer of the allocator. It formats the header store, walks the block
// list for allocate and coalesce, clears allocated bits for free, and
// registers one response per accepted request.
// ----------------------------------------------------------------------------
module ffha_seq #(
  parameter int unsigned HEAP_WORDS = ffha_pkg::HEAP_WORDS_DEF,
  parameter int unsigned IDX_W      = $clog2(HEAP_WORDS),
  parameter int unsigned UW         = ((IDX_W > 12) ? IDX_W : 12) + 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Request side
  input  logic                         start_i,
  output logic                         busy_o,
  input  ffha_pkg::ffha_req_t          req_i,
  // Configuration side
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [ffha_pkg::CFG_W-1:0]   cfg_data_i,
  // Response side
  output logic                         done_o,
  output ffha_pkg::ffha_rsp_t          rsp_o,
  // Header store
  output logic                         mem_we_o,
  output logic [IDX_W-1:0]             mem_waddr_o,
  output logic [ffha_pkg::HDR_W-1:0]   mem_wdata_o,
  output logic [IDX_W-1:0]             mem_raddr_o,
  input  logic [ffha_pkg::HDR_W-1:0]   mem_rdata_i,
  // Shared arithmetic unit
  output logic [UW-1:0]                alu_a_o,
  output logic [UW-1:0]                alu_b_o,
  output logic                         alu_sub_o,
  input  logic [UW-1:0]                alu_res_i,
  input  logic                         alu_cout_i
);

  import ffha_pkg::*;

  localparam int unsigned STP_W = IDX_W + 1;
  localparam int unsigned CAP   = (HEAP_WORDS * 4 / 8) * 8;
  localparam int unsigned CAP_W = 20;

  localparam logic [UW-1:0]    HW_U     = UW'(HEAP_WORDS);
  localparam logic [STP_W-1:0] HW_S     = STP_W'(HEAP_WORDS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HEAP_WORDS - 1);
  localparam logic [IDX_W-1:0] FIRST_IDX = IDX_W'(1);
  localparam logic [CAP_W-1:0] CAP_V    = CAP_W'(CAP);

  // Sequencer states.
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLR   = 4'd1;
  localparam logic [3:0] S_A_CHK = 4'd2;
  localparam logic [3:0] S_A_HDR = 4'd3;
  localparam logic [3:0] S_A_ADV = 4'd4;
  localparam logic [3:0] S_A_SPL = 4'd5;
  localparam logic [3:0] S_A_MRK = 4'd6;
  localparam logic [3:0] S_F_RD  = 4'd7;
  localparam logic [3:0] S_F_WR  = 4'd8;
  localparam logic [3:0] S_C_INI = 4'd9;
  localparam logic [3:0] S_C_HC  = 4'd10;
  localparam logic [3:0] S_C_TOP = 4'd11;
  localparam logic [3:0] S_C_HN  = 4'd12;
  localparam logic [3:0] S_NOP   = 4'd13;

  logic [3:0]        state_q, state_d;
  logic [IDX_W-1:0]  clr_q, clr_d;
  logic [CFG_W-1:0]  heap_q, heap_d;
  logic [UW-1:0]     idx_q, idx_d;
  logic [STP_W-1:0]  steps_q, steps_d;
  logic              done_q, done_d;
  ffha_req_t         req_q, req_d;
  logic [UW-1:0]     nxt_q, nxt_d;
  logic [HDR_W-1:0]  hdr_q, hdr_d;
  logic [HDR_W-1:0]  rem_q, rem_d;
  ffha_rsp_t         rsp_q, rsp_d;

  logic [HDR_W-1:0]  need_raw, need;
  logic [UW-1:0]     need_words;
  logic [UW-1:0]     sw_hdr;
  logic [UW+1:0]     off_full;
  logic [HDR_W-1:0]  tot_raw, tot_al, total;
  logic [HDR_W-1:0]  first_hdr;
  logic [UW-1:0]     end_idx;
  logic [UW-1:0]     free_idx;
  logic              free_skip;
  logic              fin, fin_ok, fin_alloc;

  // Request size rounded up to 8 bytes with the header word included.
  assign need_raw   = {1'b0, req_q.request_bytes} + 13'd11;
  assign need       = {need_raw[HDR_W-1:3], 3'b000};
  assign need_words = UW'(need[HDR_W-1:2]);

  // Block size of the latched header, in words.
  assign sw_hdr = UW'(hdr_q[HDR_W-1:2]);

  // Payload offset of the block at idx_q.
  assign off_full = {idx_q, 2'b00} + (UW+2)'(4);

  // Format values derived from the heap size register.
  assign tot_raw   = {1'b0, heap_q} + 13'd19;
  assign tot_al    = {tot_raw[HDR_W-1:3], 3'b000};
  assign total     = ({7'd0, tot_al} > CAP_V) ? CAP_V[HDR_W-1:0] : tot_al;
  assign first_hdr = total - 13'd8;
  assign end_idx   = UW'(total[HDR_W-1:2]) - UW'(1);

  // Header word addressed by a free request.
  assign free_idx  = UW'(req_q.address[BYTE_W-1:2]) - UW'(1);
  assign free_skip = (req_q.address[BYTE_W-1:2] == '0) || (free_idx >= HW_U);

  // Next-state and datapath logic.
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    heap_d      = heap_q;
    idx_d       = idx_q;
    steps_d     = steps_q;
    done_d      = 1'b0;
    req_d       = req_q;
    nxt_d       = nxt_q;
    hdr_d       = hdr_q;
    rem_d       = rem_q;
    rsp_d       = rsp_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = idx_q[IDX_W-1:0];
    mem_wdata_o = '0;
    mem_raddr_o = idx_q[IDX_W-1:0];
    alu_a_o     = idx_q;
    alu_b_o     = sw_hdr;
    alu_sub_o   = 1'b0;
    fin         = 1'b0;
    fin_ok      = 1'b1;
    fin_alloc   = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          req_d   = req_i;
          idx_d   = UW'(1);
          steps_d = '0;
          case (req_i.func)
            FUNC_ALLOC: state_d = S_A_CHK;
            FUNC_FREE:  state_d = S_F_RD;
            FUNC_MERGE: state_d = S_C_INI;
            default:    state_d = S_NOP;
          endcase
        end
      end

      S_NOP: begin
        fin = 1'b1;
      end

      // Clearing pass: one word per cycle, first header and end mark included.
      S_CLR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = clr_q;
        if (clr_q == FIRST_IDX) begin
          mem_wdata_o = first_hdr;
        end else if (UW'(clr_q) == end_idx) begin
          mem_wdata_o = END_MARK;
        end else begin
          mem_wdata_o = '0;
        end
        clr_d = clr_q + IDX_W'(1);
        if (clr_q == LAST_IDX) begin
          state_d = S_IDLE;
        end
      end

      // Allocate: bound checks, then read the header at idx_q.
      S_A_CHK: begin
        if ((steps_q == HW_S) || (idx_q >= HW_U)) begin
          fin    = 1'b1;
          fin_ok = 1'b0;
        end else begin
          mem_raddr_o = idx_q[IDX_W-1:0];
          state_d     = S_A_HDR;
        end
      end

      // Allocate: fit check by subtracting the needed size.
      S_A_HDR: begin
        hdr_d     = mem_rdata_i;
        alu_a_o   = UW'(mem_rdata_i);
        alu_b_o   = UW'(need);
        alu_sub_o = 1'b1;
        if ((mem_rdata_i == END_MARK) || (mem_rdata_i[HDR_W-1:2] == '0)) begin
          fin    = 1'b1;
          fin_ok = 1'b0;
        end else if (!mem_rdata_i[0] && !alu_cout_i) begin
          rem_d   = alu_res_i[HDR_W-1:0];
          state_d = S_A_SPL;
        end else begin
          state_d = S_A_ADV;
        end
      end

      // Allocate: step to the next block.
      S_A_ADV: begin
        idx_d   = alu_res_i;
        steps_d = steps_q + STP_W'(1);
        state_d = S_A_CHK;
      end

      // Allocate: place the remainder header past the granted block.
      S_A_SPL: begin
        alu_b_o = need_words;
        if (alu_res_i > HW_U) begin
          fin    = 1'b1;
          fin_ok = 1'b0;
        end else if (rem_q != '0) begin
          if (alu_res_i >= HW_U) begin
            fin    = 1'b1;
            fin_ok = 1'b0;
          end else begin
            mem_we_o    = 1'b1;
            mem_waddr_o = alu_res_i[IDX_W-1:0];
            mem_wdata_o = rem_q;
            state_d     = S_A_MRK;
          end
        end else begin
          state_d = S_A_MRK;
        end
      end

      // Allocate: mark the granted block as allocated.
      S_A_MRK: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = idx_q[IDX_W-1:0];
        mem_wdata_o = {need[HDR_W-1:1], 1'b1};
        fin         = 1'b1;
        fin_alloc   = 1'b1;
      end

      // Free: read the addressed header unless the address is out of range.
      S_F_RD: begin
        if (free_skip) begin
          fin = 1'b1;
        end else begin
          mem_raddr_o = free_idx[IDX_W-1:0];
          state_d     = S_F_WR;
        end
      end

      // Free: write it back with the allocated bit cleared.
      S_F_WR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = free_idx[IDX_W-1:0];
        mem_wdata_o = {mem_rdata_i[HDR_W-1:1], 1'b0};
        fin         = 1'b1;
      end

      // Coalesce: read the first header.
      S_C_INI: begin
        mem_raddr_o = idx_q[IDX_W-1:0];
        state_d     = S_C_HC;
      end

      S_C_HC: begin
        hdr_d   = mem_rdata_i;
        state_d = S_C_TOP;
      end

      // Coalesce: find and read the following header.
      S_C_TOP: begin
        if ((steps_q == HW_S) || (hdr_q[HDR_W-1:2] == '0) || (alu_res_i >= HW_U)) begin
          fin = 1'b1;
        end else begin
          mem_raddr_o = alu_res_i[IDX_W-1:0];
          nxt_d       = alu_res_i;
          state_d     = S_C_HN;
        end
      end

      // Coalesce: merge two free neighbors or move on.
      S_C_HN: begin
        alu_a_o = UW'(hdr_q);
        alu_b_o = UW'(mem_rdata_i);
        if (mem_rdata_i == END_MARK) begin
          fin = 1'b1;
        end else begin
          steps_d = steps_q + STP_W'(1);
          state_d = S_C_TOP;
          if (!hdr_q[0] && !mem_rdata_i[0]) begin
            mem_we_o    = 1'b1;
            mem_waddr_o = idx_q[IDX_W-1:0];
            mem_wdata_o = alu_res_i[HDR_W-1:0];
            hdr_d       = alu_res_i[HDR_W-1:0];
          end else begin
            idx_d = nxt_q;
            hdr_d = mem_rdata_i;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Response register load at the end of an operation.
    if (fin) begin
      state_d                = S_IDLE;
      done_d                 = 1'b1;
      rsp_d.ok               = fin_ok;
      rsp_d.payload_offset   = fin_alloc ? off_full[BYTE_W-1:0] : '0;
      rsp_d.granted_bytes    = fin_alloc ? need : '0;
    end

    // A heap size write restarts the clearing pass.
    if (cfg_valid_i && cfg_ready_o) begin
      heap_d  = cfg_data_i;
      clr_d   = '0;
      state_d = S_CLR;
    end
  end

  // A request transfer in the same cycle wins; the heap_size write waits.
  assign cfg_ready_o = ((state_q == S_IDLE) && !start_i) || (state_q == S_CLR);
  assign busy_o      = (state_q != S_IDLE);
  assign done_o      = done_q;
  assign rsp_o       = rsp_q;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      clr_q   <= '0;
      heap_q  <= HEAP_SIZE_RST;
      idx_q   <= '0;
      steps_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      heap_q  <= heap_d;
      idx_q   <= idx_d;
      steps_q <= steps_d;
      done_q  <= done_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    nxt_q <= nxt_d;
    hdr_q <= hdr_d;
    rem_q <= rem_d;
    rsp_q <= rsp_d;
  end

endmodule

// ----- hw/rtl/ffha_checker.sv -----
// ----------------------------------------------------------------------------
// ffha_checker
// Port-level checks of the heap allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "first_fit_heap_allocator_top_assert.svh"

module ffha_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       start,
  input logic                       busy,
  input logic                       cfg_valid_i,
  input logic                       cfg_ready_o,
  input logic                       done_o,
  input ffha_pkg::ffha_rsp_t        rsp_o
);

  // An accepted request raises busy.
  `FFHA_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "request transfer did not raise busy")

  // A heap size transfer starts the clearing pass.
  `FFHA_ASSERT_NEXT(a_cfg_busy, cfg_valid_i && cfg_ready_o, busy, "config transfer did not raise busy")

  // The response strobe comes with the block idle again.
  `FFHA_ASSERT_SAME(a_done_idle, done_o, !busy, "response strobe while busy")

  // A failed allocation reports no offset and no size.
  `FFHA_ASSERT_SAME(a_fail_zero, done_o && !rsp_o.ok,
                    (rsp_o.payload_offset == '0) && (rsp_o.granted_bytes == '0),
                    "failed response carries nonzero fields")

endmodule

bind first_fit_heap_allocator_top ffha_checker u_ffha_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o),
  .done_o      (done_o),
  .rsp_o       (rsp_o)
);
